FILE: hdl/scte_pkg.sv
// ----------------------------------------------------------------------------
// scte_pkg: shared types and constants
// Widths of the number path and the queue item format.
// ----------------------------------------------------------------------------
`default_nettype none
package scte_pkg;

  localparam int unsigned NumberWidth = 32;
  // trial divisor reaches just past the square root of the largest number
  localparam int unsigned DivWidth    = NumberWidth / 2 + 1;
  localparam int unsigned SqWidth     = 2 * DivWidth;
  localparam int unsigned CntWidth    = $clog2(NumberWidth);
  localparam int unsigned QueueDepth  = 2;

  typedef struct packed {
    logic [NumberWidth-1:0] number;
    logic                   trivial;  // decided in the front, no search needed
    logic                   verdict;  // composite flag for trivial items
  } item_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StSq   = 5'b00010,
    StCmp  = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/scte_front.sv
// ----------------------------------------------------------------------------
// scte_front: input side
// Takes numbers and settles the cases that need no search.
// ----------------------------------------------------------------------------
`default_nettype none
module scte_front (
  input  wire logic                            valid_i,
  input  wire logic [scte_pkg::NumberWidth-1:0] number_i,
  output      logic                            stall_o,
  input  wire logic                            full_i,
  output      logic                            push_o,
  output      scte_pkg::item_t                 item_o
);

  logic small_w;

  // below four or even: no search
  assign small_w = (number_i < scte_pkg::NumberWidth'(4));

  always_comb begin
    item_o.number  = number_i;
    item_o.trivial = small_w | ~number_i[0];
    // only two and three are prime among these
    item_o.verdict = ~((number_i == scte_pkg::NumberWidth'(2)) |
                       (number_i == scte_pkg::NumberWidth'(3)));
  end

  assign stall_o = full_i;
  assign push_o  = valid_i & ~full_i;

endmodule
`default_nettype wire

FILE: hdl/scte_fifo.sv
// ----------------------------------------------------------------------------
// scte_fifo: item queue
// Short register queue between the front and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none
module scte_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire scte_pkg::item_t item_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      scte_pkg::item_t item_o
);

  localparam int unsigned PtrWidth = $clog2(scte_pkg::QueueDepth);

  scte_pkg::item_t                      mem_q [scte_pkg::QueueDepth];
  logic [PtrWidth-1:0]                  wr_q, wr_d, rd_q, rd_d;
  logic [PtrWidth:0]                    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrWidth+1)'(scte_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrWidth+1)'(push_i) - (PtrWidth+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrWidth+1)'(scte_pkg::QueueDepth)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

FILE: hdl/scte_back.sv
// ----------------------------------------------------------------------------
// scte_back: search engine
// Odd trial divisors up to the square root, bit-serial remainder per divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module scte_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire scte_pkg::item_t item_i,
  output      logic            pop_o,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      logic            is_composite_o
);

  localparam int unsigned NW = scte_pkg::NumberWidth;
  localparam int unsigned DW = scte_pkg::DivWidth;
  localparam int unsigned SW = scte_pkg::SqWidth;
  localparam int unsigned CW = scte_pkg::CntWidth;

  scte_pkg::state_e  state_q, state_d;
  logic [NW-1:0]     n_q, n_d, num_q, num_d;
  logic [DW-1:0]     d_q, d_d, rem_q, rem_d;
  logic [SW-1:0]     sq_q, sq_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              res_q, res_d;
  logic              ovld_q, ovld_d, ores_q, ores_d;
  logic [DW:0]       shift_w;
  logic [DW-1:0]     step_w;

  // one restoring step of n mod d
  assign shift_w = {rem_q, num_q[NW-1]};
  assign step_w  = (shift_w >= {1'b0, d_q}) ? DW'(shift_w - {1'b0, d_q}) : shift_w[DW-1:0];

  assign pop_o          = (state_q == scte_pkg::StIdle) & ~empty_i;
  assign out_valid_o    = ovld_q;
  assign is_composite_o = ores_q;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    num_d   = num_q;
    d_d     = d_q;
    rem_d   = rem_q;
    sq_d    = sq_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    ovld_d  = ovld_q & out_stall_i;
    ores_d  = ores_q;
    unique case (state_q)
      scte_pkg::StIdle: begin
        if (!empty_i) begin
          n_d   = item_i.number;
          res_d = item_i.verdict;
          d_d   = DW'(3);
          state_d = item_i.trivial ? scte_pkg::StDone : scte_pkg::StSq;
        end
      end
      scte_pkg::StSq: begin
        sq_d    = SW'(d_q) * SW'(d_q);
        state_d = scte_pkg::StCmp;
      end
      scte_pkg::StCmp: begin
        if (sq_q > SW'(n_q)) begin
          res_d   = 1'b0;
          state_d = scte_pkg::StDone;
        end else begin
          rem_d   = '0;
          num_d   = n_q;
          cnt_d   = '0;
          state_d = scte_pkg::StDiv;
        end
      end
      scte_pkg::StDiv: begin
        rem_d = step_w;
        num_d = {num_q[NW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          if (step_w == '0) begin
            res_d   = 1'b1;
            state_d = scte_pkg::StDone;
          end else begin
            d_d     = d_q + DW'(2);
            state_d = scte_pkg::StSq;
          end
        end
      end
      scte_pkg::StDone: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          ores_d  = res_q;
          state_d = scte_pkg::StIdle;
        end
      end
      default: state_d = scte_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scte_pkg::StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    num_q  <= num_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
    sq_q   <= sq_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    ores_q <= ores_d;
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scte_pkg::StDiv) |-> (rem_q < d_q)) else $error("remainder not reduced");
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scte_pkg::StCmp) |-> (d_q[0] && d_q >= DW'(3))) else $error("bad divisor");
  a_search_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scte_pkg::StSq) |-> n_q[0]) else $error("even number in search");
`endif

endmodule
`default_nettype wire

FILE: hdl/staircase_composite_test.sv
// Search: 0, 1, 2, 3 and even numbers skip the search; for other numbers each
//   odd trial divisor up to sqrt(n) costs a square, a compare and a bit-serial
//   remainder over all NumberWidth bits. The search engine works on one
//   number at a time; a two-entry queue lets the input side keep taking
//   numbers meanwhile, until the queue is full.
// Reset: rst_ni asynchronous, active low; clears queue, engine and output.
// ----------------------------------------------------------------------------
// staircase_composite_test: composite number detector
// The staircase searches hit exactly for composite n, so the block decides
// compositeness by trial division with odd divisors up to the square root.
// ----------------------------------------------------------------------------
`default_nettype none
module staircase_composite_test (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [scte_pkg::NumberWidth-1:0] number_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             is_composite_o
);

  // front to queue
  logic            push_w;
  logic            full_w;
  scte_pkg::item_t front_item_w;
  // queue to engine
  logic            pop_w;
  logic            empty_w;
  scte_pkg::item_t queue_item_w;

  // Front: each transfer is classified at once; trivial cases carry a verdict
  scte_front u_front (
    .valid_i  (in_valid_i),
    .number_i (number_i),
    .stall_o  (in_stall_o),
    .full_i   (full_w),
    .push_o   (push_w),
    .item_o   (front_item_w)
  );

  scte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .item_i  (front_item_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .empty_o (empty_w),
    .item_o  (queue_item_w)
  );

  // Back: square check, then bit-serial remainder per odd divisor;
  // the result sits in an output register until transferred
  scte_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty_w),
    .item_i         (queue_item_w),
    .pop_o          (pop_w),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_composite_o (is_composite_o)
  );

endmodule
`default_nettype wire
